### hw/rtl/gblb_pkg.sv
// ---------------------------------------------------------------------------
// gblb_pkg: shared types and constants of the Gaussian blur line buffer
// Transaction layouts, register indexes, kernel weight tables.
// ---------------------------------------------------------------------------
`default_nettype none

package gblb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_KERNEL = 7;
   localparam int NLINES     = MAX_KERNEL - 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int WT_W       = 13;
   localparam int PROD_W     = 8 + WT_W;
   localparam int ROWSUM_W   = PROD_W + 2;
   localparam int SUM_W      = 25;
   localparam int NUM_W      = 18;
   localparam int QUOT_W     = 9;
   localparam int DIV5       = 546;
   localparam int RECIP5     = 30727;   // floor(2^24 / 546)

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd2;

   // operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // kernel mode codes; the spare code also selects 7x7
   localparam logic [1:0] MODE_3X3     = 2'd0;
   localparam logic [1:0] MODE_5X5     = 2'd1;
   localparam logic [1:0] MODE_7X7     = 2'd2;
   localparam logic [1:0] MODE_7X7_ALT = 2'd3;

   // kernel radius codes
   localparam logic [1:0] RAD_3X3 = 2'd1;
   localparam logic [1:0] RAD_5X5 = 2'd2;
   localparam logic [1:0] RAD_7X7 = 2'd3;

   typedef struct packed {
      logic       operation;
      logic [7:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0] blurred_value;
      logic       end_of_row;
      logic       end_of_frame;
      logic       last_in_run;
   } rsp_type;

   // window[k][j]: k rows back, j columns back
   typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][7:0] win_type;

   typedef struct packed {
      logic [1:0] radius;
      logic [1:0] col_gap;       // newest column minus output column
      logic       end_of_row;
      logic       end_of_frame;
      logic       last_in_run;
   } job_type;

   typedef struct packed {
      logic [1:0]        radius;
      logic [NUM_W-1:0]  num;
      logic [QUOT_W-1:0] quot;
      logic              end_of_row;
      logic              end_of_frame;
      logic              last_in_run;
   } res_type;

   localparam logic [WT_W-1:0] W3 [3][3] = '{
      '{13'd1, 13'd2, 13'd1},
      '{13'd2, 13'd4, 13'd2},
      '{13'd1, 13'd2, 13'd1}
   };

   localparam logic [WT_W-1:0] W5 [5][5] = '{
      '{13'd1, 13'd4,  13'd7,  13'd4,  13'd1},
      '{13'd4, 13'd16, 13'd26, 13'd16, 13'd4},
      '{13'd7, 13'd26, 13'd41, 13'd26, 13'd7},
      '{13'd4, 13'd16, 13'd26, 13'd16, 13'd4},
      '{13'd1, 13'd4,  13'd7,  13'd4,  13'd1}
   };

   localparam logic [WT_W-1:0] W7 [7][7] = '{
      '{13'd56,  13'd191,  13'd413,  13'd549,  13'd413,  13'd191,  13'd56},
      '{13'd191, 13'd697,  13'd1493, 13'd1987, 13'd1493, 13'd697,  13'd191},
      '{13'd413, 13'd1493, 13'd3209, 13'd4270, 13'd3209, 13'd1493, 13'd413},
      '{13'd549, 13'd1987, 13'd4270, 13'd5677, 13'd4270, 13'd1987, 13'd549},
      '{13'd413, 13'd1493, 13'd3209, 13'd4270, 13'd3209, 13'd1493, 13'd413},
      '{13'd191, 13'd697,  13'd1493, 13'd1987, 13'd1493, 13'd697,  13'd191},
      '{13'd56,  13'd191,  13'd413,  13'd549,  13'd413,  13'd191,  13'd56}
   };

   // weight of tap (dy, dx) for the given radius, zero outside the kernel
   function automatic logic [WT_W-1:0] kern_weight(input logic [1:0] rad,
                                                   input int dy, input int dx);
      logic [WT_W-1:0] w;
      w = '0;
      case (rad)
         RAD_3X3: if (dy < 3 && dx < 3) w = W3[dy][dx];
         RAD_5X5: if (dy < 5 && dx < 5) w = W5[dy][dx];
         default: w = W7[dy][dx];
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/gblb_front.sv
// ---------------------------------------------------------------------------
// gblb_front: input control, line store, window and result sequencer
// Counts columns and rows, reads/writes the line store, shifts the window
// and issues one filter job per result column.
// ---------------------------------------------------------------------------
`default_nettype none

module gblb_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [gblb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [gblb_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire gblb_pkg::req_type                   req_payload,
   input  wire logic                                pipe_en,
   output gblb_pkg::win_type                        window,
   output logic                                     job_valid,
   output gblb_pkg::job_type                        job
);

   localparam int CW = gblb_pkg::COL_W;
   localparam int RW = gblb_pkg::ROW_W;
   localparam int LW = gblb_pkg::NLINES * 8;

   // configuration
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [1:0]  mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         mode_ff   <= gblb_pkg::MODE_5X5;
      end else if (csr_valid) begin
         unique case (csr_index)
            gblb_pkg::CSR_WIDTH:  width_ff  <= csr_data[11:0];
            gblb_pkg::CSR_HEIGHT: height_ff <= csr_data;
            gblb_pkg::CSR_MODE:   mode_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // effective settings
   logic [CW-1:0] w_m1;
   logic [RW-1:0] h_eff;
   logic [1:0]    rad;

   always_comb begin
      if (width_ff == 12'd0)
         w_m1 = '0;
      else if (width_ff > 12'(gblb_pkg::MAX_WIDTH))
         w_m1 = CW'(gblb_pkg::MAX_WIDTH - 1);
      else
         w_m1 = CW'(width_ff - 12'd1);
      if (height_ff == 13'd0)
         h_eff = RW'(1);
      else if (height_ff > 13'(gblb_pkg::MAX_HEIGHT))
         h_eff = RW'(gblb_pkg::MAX_HEIGHT);
      else
         h_eff = height_ff;
      if (mode_ff == gblb_pkg::MODE_3X3)      rad = gblb_pkg::RAD_3X3;
      else if (mode_ff == gblb_pkg::MODE_5X5) rad = gblb_pkg::RAD_5X5;
      else                                    rad = gblb_pkg::RAD_7X7;
   end

   // position and output range of the incoming item
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   logic [CW-1:0] cur_c, lo, hi;
   logic [RW-1:0] cur_y;
   logic [RW:0]   row_inc, row_lim;
   logic          op_ok, row_end, c_ge_r, any_out, y_last, accept;
   logic          job_more, s1_go;

   // job sequencer state
   logic          job_valid_ff, job_ylast_ff;
   logic [CW-1:0] job_x_ff, job_hi_ff, job_c_ff, job_wm1_ff;
   logic [1:0]    job_r_ff;

   always_comb begin
      cur_c   = (col_cnt_ff > w_m1) ? w_m1 : col_cnt_ff;
      op_ok   = (row_cnt_ff < h_eff) ? (req_payload.operation == gblb_pkg::OP_PIXEL)
                                     : (req_payload.operation == gblb_pkg::OP_FLUSH);
      row_end = (cur_c == w_m1);
      c_ge_r  = (cur_c >= CW'(rad));
      cur_y   = row_cnt_ff - RW'(rad);
      any_out = (row_cnt_ff >= RW'(rad)) && (cur_y < h_eff) && (row_end || c_ge_r);
      y_last  = (cur_y == h_eff - RW'(1));
      lo      = c_ge_r ? cur_c - CW'(rad) : '0;
      hi      = row_end ? w_m1 : lo;
      row_inc = {1'b0, row_cnt_ff} + (RW+1)'(1);
      row_lim = {1'b0, h_eff} + (RW+1)'(rad);
   end

   assign job_more  = job_valid && (job_x_ff != job_hi_ff);
   assign s1_go     = pipe_en && !job_more;
   assign req_stall = !s1_go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (accept && op_ok) begin
         if (row_end) begin
            col_cnt_in = '0;
            row_cnt_in = (row_inc >= row_lim) ? '0 : RW'(row_inc);
         end else begin
            col_cnt_in = cur_c + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // stage 1: line store read in flight
   logic          s1_valid_ff, s1_flush_ff, s1_first_ff, s1_any_ff, s1_ylast_ff;
   logic [7:0]    s1_pix_ff;
   logic [CW-1:0] s1_c_ff, s1_lo_ff, s1_hi_ff, s1_wm1_ff;
   logic [1:0]    s1_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s1_valid_ff <= accept && op_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_flush_ff <= (row_cnt_ff >= h_eff);
         s1_first_ff <= (row_cnt_ff == '0);
         s1_any_ff   <= any_out;
         s1_ylast_ff <= y_last;
         s1_pix_ff   <= req_payload.pixel_value;
         s1_c_ff     <= cur_c;
         s1_lo_ff    <= lo;
         s1_hi_ff    <= hi;
         s1_wm1_ff   <= w_m1;
         s1_r_ff     <= rad;
      end
   end

   // line store: one word per column, line 0 in the low byte
   logic [LW-1:0] line_mem [gblb_pkg::MAX_WIDTH];
   logic [LW-1:0] rd_data_ff, fwd_data_ff, lines, wr_data;
   logic [CW-1:0] rd_addr;
   logic          wr_en, fwd_ff;

   assign rd_addr = s1_go ? cur_c : s1_c_ff;
   assign wr_en   = s1_go && s1_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[s1_c_ff] <= wr_data;
      end
      rd_data_ff  <= line_mem[rd_addr];
      fwd_data_ff <= wr_data;
   end

   // read and write of the same column in one cycle: take the new word
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= wr_en && (s1_c_ff == rd_addr);
      end
   end

   assign lines = fwd_ff ? fwd_data_ff : rd_data_ff;

   logic [7:0] pix;
   logic [gblb_pkg::MAX_KERNEL-1:0][7:0] col;

   always_comb begin
      pix    = s1_flush_ff ? lines[7:0] : s1_pix_ff;
      col[0] = pix;
      for (int k = 1; k < gblb_pkg::MAX_KERNEL; k++) begin
         col[k] = s1_first_ff ? pix : lines[(k-1)*8 +: 8];
      end
      wr_data = s1_first_ff ? {gblb_pkg::NLINES{pix}} : {lines[LW-9:0], pix};
   end

   // window
   gblb_pkg::win_type window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (wr_en) begin
         for (int k = 0; k < gblb_pkg::MAX_KERNEL; k++) begin
            for (int j = 0; j < gblb_pkg::MAX_KERNEL; j++) begin
               if (s1_c_ff == '0 || j == 0) window_ff[k][j] <= col[k];
               else                         window_ff[k][j] <= window_ff[k][j-1];
            end
         end
      end
   end

   assign window = window_ff;

   // job sequencer: one output column per cycle while pipe_en is high
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (pipe_en && !job_more) begin
         job_valid_ff <= s1_valid_ff && s1_any_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         if (job_more) begin
            job_x_ff <= job_x_ff + CW'(1);
         end else begin
            job_x_ff     <= s1_lo_ff;
            job_hi_ff    <= s1_hi_ff;
            job_c_ff     <= s1_c_ff;
            job_wm1_ff   <= s1_wm1_ff;
            job_r_ff     <= s1_r_ff;
            job_ylast_ff <= s1_ylast_ff;
         end
      end
   end

   assign job_valid        = job_valid_ff;
   assign job.radius       = job_r_ff;
   assign job.col_gap      = 2'(job_c_ff - job_x_ff);
   assign job.end_of_row   = (job_x_ff == job_wm1_ff);
   assign job.end_of_frame = (job_x_ff == job_wm1_ff) && job_ylast_ff;
   assign job.last_in_run  = (job_x_ff == job_hi_ff);

endmodule

`default_nettype wire

### hw/rtl/gblb_filter.sv
// ---------------------------------------------------------------------------
// gblb_filter: kernel arithmetic pipeline
// Tap gather with border clamp, per-row weighted sums, total, rounding.
// ---------------------------------------------------------------------------
`default_nettype none

module gblb_filter (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pipe_en,
   input  wire gblb_pkg::win_type   window,
   input  wire logic                job_valid,
   input  wire gblb_pkg::job_type   job,
   output logic                     res_valid,
   output gblb_pkg::res_type        res
);

   localparam int K = gblb_pkg::MAX_KERNEL;

   typedef struct packed {
      logic [1:0] radius;
      logic       end_of_row;
      logic       end_of_frame;
      logic       last_in_run;
   } tag_type;

   // gather
   gblb_pkg::win_type g_pix, g_pix_ff;
   tag_type g_tag_ff, m_tag_ff, t_tag_ff;
   logic    g_valid_ff, m_valid_ff, t_valid_ff, r_valid_ff;

   always_comb begin
      int kk;
      int jj;
      for (int dy = 0; dy < K; dy++) begin
         for (int dx = 0; dx < K; dx++) begin
            kk = 2 * int'(job.radius) - dy;
            if (kk < 0 || kk > K - 1) kk = K - 1;
            jj = int'(job.col_gap) + int'(job.radius) - dx;
            if (jj < 0) jj = 0;
            if (jj > K - 1) jj = K - 1;
            g_pix[dy][dx] = window[kk][jj];
         end
      end
   end

   // per-row weighted sums
   logic [K-1:0][gblb_pkg::ROWSUM_W-1:0] m_row, m_row_ff;

   always_comb begin
      for (int dy = 0; dy < K; dy++) begin
         m_row[dy] = '0;
         for (int dx = 0; dx < K; dx++) begin
            m_row[dy] = m_row[dy] + gblb_pkg::ROWSUM_W'(g_pix_ff[dy][dx] *
                        gblb_pkg::kern_weight(g_tag_ff.radius, dy, dx));
         end
      end
   end

   // total
   logic [gblb_pkg::SUM_W-1:0] t_sum, t_sum_ff;

   always_comb begin
      t_sum = '0;
      for (int dy = 0; dy < K; dy++) begin
         t_sum = t_sum + gblb_pkg::SUM_W'(m_row_ff[dy]);
      end
   end

   // rounding; 5x5 divides by 546 through a reciprocal, corrected downstream
   logic [gblb_pkg::NUM_W-1:0]  num;
   logic [32:0]                 prod;
   logic [gblb_pkg::QUOT_W-1:0] quot;
   logic [gblb_pkg::SUM_W-1:0]  rnd;
   gblb_pkg::res_type           r_res_ff;

   always_comb begin
      num  = gblb_pkg::NUM_W'({t_sum_ff, 1'b0} + 26'd273);
      prod = 33'(num) * 33'(gblb_pkg::RECIP5);
      rnd  = '0;
      case (t_tag_ff.radius)
         gblb_pkg::RAD_3X3: begin
            rnd  = t_sum_ff + gblb_pkg::SUM_W'(8);
            quot = gblb_pkg::QUOT_W'(rnd >> 4);
         end
         gblb_pkg::RAD_5X5: quot = prod[32:24];
         default: begin
            rnd  = t_sum_ff + gblb_pkg::SUM_W'(32768);
            quot = gblb_pkg::QUOT_W'(rnd >> 16);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         t_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         g_valid_ff <= job_valid;
         m_valid_ff <= g_valid_ff;
         t_valid_ff <= m_valid_ff;
         r_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         g_pix_ff              <= g_pix;
         g_tag_ff.radius       <= job.radius;
         g_tag_ff.end_of_row   <= job.end_of_row;
         g_tag_ff.end_of_frame <= job.end_of_frame;
         g_tag_ff.last_in_run  <= job.last_in_run;
         m_row_ff              <= m_row;
         m_tag_ff              <= g_tag_ff;
         t_sum_ff              <= t_sum;
         t_tag_ff              <= m_tag_ff;
         r_res_ff.radius       <= t_tag_ff.radius;
         r_res_ff.num          <= num;
         r_res_ff.quot         <= quot;
         r_res_ff.end_of_row   <= t_tag_ff.end_of_row;
         r_res_ff.end_of_frame <= t_tag_ff.end_of_frame;
         r_res_ff.last_in_run  <= t_tag_ff.last_in_run;
      end
   end

   assign res_valid = r_valid_ff;
   assign res       = r_res_ff;

endmodule

`default_nettype wire

### hw/rtl/gaussian_blur_line_buffer_unit.sv
// ---------------------------------------------------------------------------
// gaussian_blur_line_buffer_unit: streaming Gaussian blur, clamped borders
// 3x3 / 5x5 / 7x7 kernel on 8-bit grayscale, line store plus window.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  req     | in        | req_valid/req_stall  | operation, pixel_value
//  rsp     | out       | rsp_valid/rsp_stall  | blurred_value, row/frame/run flags
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
//  One pixel transaction per cycle while req_stall is low. At the last
//  column of an output row one transaction yields up to radius+1 results,
//  one per cycle unless rsp is held; the result sequencer holds req_stall
//  until the last of them is issued. The first result of a transaction
//  passes through 7 register stages after the accepting edge: line store
//  read, window, tap gather, row sums, total, rounding, output register.
//  Reset is synchronous; the line store is not cleared (row 0 fills it).
//  A held rsp stalls the whole pipe, and req_stall follows in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_line_buffer_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire gblb_pkg::req_type                req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output gblb_pkg::rsp_type                     rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gblb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gblb_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic               pipe_en;
   gblb_pkg::win_type  window;
   logic               job_valid;
   gblb_pkg::job_type  job;
   logic               res_valid;
   gblb_pkg::res_type  res;

   // output register
   logic               rsp_valid_ff;
   gblb_pkg::rsp_type  rsp_ff;

   // everything moves unless a finished result is held at the output
   assign pipe_en = !(rsp_valid_ff && rsp_stall);

   gblb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pipe_en     (pipe_en),
      .window      (window),
      .job_valid   (job_valid),
      .job         (job)
   );

   gblb_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .window    (window),
      .job_valid (job_valid),
      .job       (job),
      .res_valid (res_valid),
      .res       (res)
   );

   // 5x5 quotient fix-up: the reciprocal estimate is low by at most one
   logic [gblb_pkg::NUM_W-1:0]  rem;
   logic [gblb_pkg::QUOT_W-1:0] val;
   logic [7:0]                  sat;

   always_comb begin
      rem = res.num - gblb_pkg::NUM_W'(gblb_pkg::NUM_W'(res.quot) *
                                       gblb_pkg::NUM_W'(gblb_pkg::DIV5));
      if (res.radius == gblb_pkg::RAD_5X5 && rem >= gblb_pkg::NUM_W'(gblb_pkg::DIV5))
         val = res.quot + gblb_pkg::QUOT_W'(1);
      else
         val = res.quot;
      sat = (val > gblb_pkg::QUOT_W'(255)) ? 8'd255 : val[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_ff.blurred_value <= sat;
         rsp_ff.end_of_row    <= res.end_of_row;
         rsp_ff.end_of_frame  <= res.end_of_frame;
         rsp_ff.last_in_run   <= res.last_in_run;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/gblb_checker.sv
// ---------------------------------------------------------------------------
// gblb_checker: port-level checks for the blur unit
// Output hold, flag consistency, back-pressure and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module gblb_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_stall,
   input wire gblb_pkg::req_type                req_payload,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire gblb_pkg::rsp_type                rsp_payload,
   input wire logic                             csr_valid,
   input wire logic                             csr_ready,
   input wire logic [gblb_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [gblb_pkg::CSR_DATA_W-1:0]  csr_data
);

   // a held transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp transaction changed while stalled");

   // end of frame only on the last column of a row
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_frame |-> rsp_payload.end_of_row)
      else $error("end_of_frame without end_of_row");

   // the last column of a row is always the last result of its run
   a_eor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.end_of_row |-> rsp_payload.last_in_run)
      else $error("end_of_row not last in run");

   // a held result stops the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while output held");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind gaussian_blur_line_buffer_unit gblb_checker u_gblb_checker (.*);

`default_nettype wire
